// ===== hw/rtl/dmc_pkg.sv =====
// Shared types, constants and codes of the direct-mapped cache timing model.
package dmc_pkg;

	// Cache geometry
	localparam int LINES       = 256;
	localparam int LINE_BITS   = $clog2(LINES + 1) - 1;
	localparam int STORE_DEPTH = 1 << LINE_BITS;
	localparam int WORD_W      = 30;
	localparam int TAG_W       = WORD_W - LINE_BITS;
	localparam int PENALTY_W   = 18;
	localparam int COUNT_W     = 32;

	// Access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Write policies
	localparam logic [1:0] POL_WT_NOALLOC = 2'd0;
	localparam logic [1:0] POL_WT_ALLOC   = 2'd1;
	localparam logic [1:0] POL_WB         = 2'd2;

	// Outcome codes
	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_HIT  = 2'd1;
	localparam logic [1:0] OUT_MISS = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_WRITE_POLICY = 2'd0;
	localparam logic [1:0] CFG_BLOCK_LOG2   = 2'd1;
	localparam logic [1:0] CFG_SETUP        = 2'd2;
	localparam logic [1:0] CFG_BURST        = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [31:0] address;
	} access_t;

	typedef struct packed {
		logic [PENALTY_W-1:0] penalty_cycles;
		logic [1:0]           outcome;
		logic [COUNT_W-1:0]   hit_total;
		logic [COUNT_W-1:0]   miss_total;
		logic [COUNT_W-1:0]   read_total;
		logic [COUNT_W-1:0]   write_total;
	} result_t;

	typedef struct packed {
		logic [1:0]  write_policy;
		logic [3:0]  block_words_log2;
		logic [15:0] miss_setup_cycles;
		logic [15:0] miss_burst_cycles;
	} cfg_t;

	// One line of the tag store
	typedef struct packed {
		logic             dirty;
		logic [TAG_W-1:0] tag;
	} tag_entry_t;

	// Lookup data handed from the store to the resolve logic
	typedef struct packed {
		logic       valid;
		tag_entry_t entry;
	} lookup_t;

	// Store update for one line
	typedef struct packed {
		logic                 en;
		logic [LINE_BITS-1:0] line;
		tag_entry_t           entry;
	} store_wr_t;

endpackage

// ===== hw/rtl/direct_mapped_cache_timing_model.sv =====
// Top level of the direct-mapped cache timing model.
//
// Usage:
//   acc channel   (acc_valid/acc_ready/acc_data): one read or write access per transfer.
//   res channel   (res_valid/res_ready/res_data): one result per access, in order, with
//                 the stall penalty, the outcome and the four running counts.
//   cfg channel   (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes, always ready;
//                 write only while no access is in flight.
// Pipeline: the tag read is registered into stage 1, where the access is resolved, and the
//   result is then registered in the result register (tag read, then resolve).
// Throughput: one access per cycle unless res_ready stalls; the tag store does one read
//   and one write per cycle; a resolve-stage line update is forwarded to the next access.
// Reset: arst_n clears all valid bits and counters at once and loads the register
//   defaults (write-back, four words per block, zero latencies); no clearing pass.
// Stall: when res_ready is low the result register holds, the resolve stage holds
//   once occupied, and acc_ready drops only when both are full.
module direct_mapped_cache_timing_model (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc_valid,
	output logic             acc_ready,
	input  dmc_pkg::access_t acc_data,
	output logic             res_valid,
	input  logic             res_ready,
	output dmc_pkg::result_t res_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import dmc_pkg::*;

	cfg_t                 cfg_q;
	logic                 accept;
	logic                 advance;
	logic [WORD_W-1:0]    word;
	logic [4:0]           tag_pos;
	logic [WORD_W-1:0]    line_word;
	logic [WORD_W-1:0]    tag_word;
	logic                 valid_s1;
	logic                 opcode_s1;
	logic [LINE_BITS-1:0] line_s1;
	logic [TAG_W-1:0]     tag_s1;
	lookup_t              lookup;
	store_wr_t            st_wr;
	store_wr_t            st_wr_raw;
	logic [PENALTY_W-1:0] penalty;
	logic [1:0]           outcome;
	logic [COUNT_W-1:0]   hit_q;
	logic [COUNT_W-1:0]   miss_q;
	logic [COUNT_W-1:0]   read_q;
	logic [COUNT_W-1:0]   write_q;
	logic [COUNT_W-1:0]   hit_next;
	logic [COUNT_W-1:0]   miss_next;
	logic [COUNT_W-1:0]   read_next;
	logic [COUNT_W-1:0]   write_next;
	logic                 res_valid_q;
	result_t              res_q;

	// Hold configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_policy      <= POL_WB;
			cfg_q.block_words_log2  <= 4'd2;
			cfg_q.miss_setup_cycles <= '0;
			cfg_q.miss_burst_cycles <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WRITE_POLICY: cfg_q.write_policy      <= cfg_data[1:0];
				CFG_BLOCK_LOG2:   cfg_q.block_words_log2  <= cfg_data[3:0];
				CFG_SETUP:        cfg_q.miss_setup_cycles <= cfg_data;
				CFG_BURST:        cfg_q.miss_burst_cycles <= cfg_data;
				default:          cfg_q                   <= cfg_q;
			endcase
		end
	end

	// Handshake: resolve stage advances when the result register is empty or being read
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign acc_ready = !valid_s1 || advance;
	assign accept    = acc_valid && acc_ready;

	// Split the word address into line index and tag
	assign word      = acc_data.address[31:2];
	assign tag_pos   = 5'(cfg_q.block_words_log2) + 5'(LINE_BITS);
	assign line_word = word >> cfg_q.block_words_log2;
	assign tag_word  = word >> tag_pos;

	dmc_tag_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_line (line_word[LINE_BITS-1:0]),
		.wr      (st_wr),
		.rd_data (lookup)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_ready) begin
			valid_s1 <= acc_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= acc_data.opcode;
			line_s1   <= line_word[LINE_BITS-1:0];
			tag_s1    <= tag_word[TAG_W-1:0];
		end
	end

	dmc_resolve u_resolve (
		.cfg     (cfg_q),
		.opcode  (opcode_s1),
		.line    (line_s1),
		.tag     (tag_s1),
		.lookup  (lookup),
		.penalty (penalty),
		.outcome (outcome),
		.wr      (st_wr_raw)
	);

	// Drop the store update unless the access leaves stage 1
	always_comb begin
		st_wr    = st_wr_raw;
		st_wr.en = st_wr_raw.en && advance;
	end

	// Next counter values
	assign hit_next   = hit_q + COUNT_W'(outcome == OUT_HIT);
	assign miss_next  = miss_q + COUNT_W'(outcome == OUT_MISS);
	assign read_next  = read_q + COUNT_W'(opcode_s1 == OP_READ);
	assign write_next = write_q + COUNT_W'(opcode_s1 == OP_WRITE);

	// Advance counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= '0;
			miss_q  <= '0;
			read_q  <= '0;
			write_q <= '0;
		end else if (advance) begin
			hit_q   <= hit_next;
			miss_q  <= miss_next;
			read_q  <= read_next;
			write_q <= write_next;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			res_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.penalty_cycles <= penalty;
			res_q.outcome        <= outcome;
			res_q.hit_total      <= hit_next;
			res_q.miss_total     <= miss_next;
			res_q.read_total     <= read_next;
			res_q.write_total    <= write_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Store is only written by an access that leaves stage 1
	a_wr_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr.en |-> advance)
		else $error("tag store written without an advancing access");

	// Input stalls only when both stages are full and the receiver holds
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_ready |-> (valid_s1 && res_valid_q && !res_ready))
		else $error("input stalled with free room");

	// Each resolved access bumps exactly one of the read and write counts
	a_rw_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> COUNT_W'(read_q + write_q) == COUNT_W'($past(read_q + write_q) + 1'b1))
		else $error("read/write counts out of step");

	// A hit bumps the hit count
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && outcome == OUT_HIT) |=> hit_q == COUNT_W'($past(hit_q) + 1'b1))
		else $error("hit count not advanced");

	// Only an uncached write skips the lookup
	a_no_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && outcome == OUT_NONE) |->
			(opcode_s1 == OP_WRITE && cfg_q.write_policy == POL_WT_NOALLOC))
		else $error("lookup skipped outside uncached write");

endmodule

// ===== hw/rtl/dmc_tag_store.sv =====
// Tag/dirty memory and valid bits of the cache, with registered read and write forwarding.
module dmc_tag_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [dmc_pkg::LINE_BITS-1:0] rd_line,
	input  dmc_pkg::store_wr_t            wr,
	output dmc_pkg::lookup_t              rd_data
);
	import dmc_pkg::*;

	tag_entry_t             mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] line_valid_q;
	tag_entry_t             rd_entry_q;
	logic                   rd_valid_q;
	logic                   fwd;

	// Same-line write in this cycle wins over the stored copy
	assign fwd = wr.en && (wr.line == rd_line);

	// Write the memory and read one line
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.line] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= fwd ? wr.entry : mem[rd_line];
		end
	end

	// Hold valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
			rd_valid_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				line_valid_q[wr.line] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= fwd ? 1'b1 : line_valid_q[rd_line];
			end
		end
	end

	assign rd_data.valid = rd_valid_q;
	assign rd_data.entry = rd_entry_q;

endmodule

// ===== hw/rtl/dmc_resolve.sv =====
// Hit check, policy decision, penalty and store update for one access.
module dmc_resolve (
	input  dmc_pkg::cfg_t                  cfg,
	input  logic                           opcode,
	input  logic [dmc_pkg::LINE_BITS-1:0]  line,
	input  logic [dmc_pkg::TAG_W-1:0]      tag,
	input  dmc_pkg::lookup_t               lookup,
	output logic [dmc_pkg::PENALTY_W-1:0]  penalty,
	output logic [1:0]                     outcome,
	output dmc_pkg::store_wr_t             wr
);
	import dmc_pkg::*;

	logic                 hit;
	logic                 dirty;
	logic                 wback;
	logic [PENALTY_W-1:0] fetch;
	logic [PENALTY_W-1:0] wword;

	// Look up the line; an invalid line never reads as dirty
	assign hit   = lookup.valid && (lookup.entry.tag == tag);
	assign dirty = lookup.valid && lookup.entry.dirty;
	assign wback = cfg.write_policy >= POL_WB;

	// Block fetch and single word write costs
	assign fetch = PENALTY_W'(cfg.miss_setup_cycles) + PENALTY_W'(cfg.miss_burst_cycles);
	assign wword = PENALTY_W'(cfg.miss_setup_cycles)
		+ PENALTY_W'(cfg.miss_burst_cycles >> cfg.block_words_log2);

	// Decide outcome, penalty and line update
	always_comb begin
		penalty        = '0;
		outcome        = OUT_NONE;
		wr.en          = 1'b0;
		wr.line        = line;
		wr.entry.tag   = tag;
		wr.entry.dirty = wback ? 1'b0 : dirty;
		if (opcode == OP_READ) begin
			if (hit) begin
				outcome = OUT_HIT;
			end else begin
				outcome = OUT_MISS;
				penalty = (wback && dirty) ? fetch + fetch : fetch;
				wr.en   = 1'b1;
			end
		end else if (cfg.write_policy == POL_WT_NOALLOC) begin
			outcome = OUT_NONE;
			penalty = wword;
		end else if (hit) begin
			outcome = OUT_HIT;
			if (wback) begin
				wr.en          = 1'b1;
				wr.entry.dirty = 1'b1;
			end else begin
				penalty = wword;
			end
		end else begin
			outcome = OUT_MISS;
			penalty = wword + fetch;
			wr.en   = 1'b1;
		end
	end

endmodule

// ===== verif/direct_mapped_cache_timing_model_tb.sv =====
// Testbench of the direct-mapped cache timing model with directed and random accesses.
module direct_mapped_cache_timing_model_tb;
	import dmc_pkg::*;

	// Unnamed policy code, behaves as write-back
	localparam logic [1:0] POL_WB_ALIAS = 2'd3;
	localparam int PRINT_CAP = 40;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    acc_valid = 1'b0;
	logic    acc_ready;
	access_t acc_data = '0;
	logic    res_valid;
	logic    res_ready = 1'b0;
	result_t res_data;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Pending accesses and the results they must produce
	access_t access_queue [$];
	result_t expected_results [$];

	// Predictor copy of the registers and the line store
	logic [1:0]  cur_policy = POL_WB;
	logic [3:0]  cur_block_log2 = 4'd2;
	logic [15:0] cur_setup = '0;
	logic [15:0] cur_burst = '0;
	bit          line_valid [STORE_DEPTH];
	bit          line_dirty [STORE_DEPTH];
	bit [31:0]   line_tag [STORE_DEPTH];
	bit [31:0]   hit_count, miss_count, read_count, write_count;

	// Pacing and bookkeeping
	bit      quiet_stretch;
	int      burst_left, gap_left, stall_left;
	int      failure_count, accepted_count, checked_count, settings_count;
	int      outcome_seen [0:3];
	result_t want;

	direct_mapped_cache_timing_model DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc_data  (acc_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		if (failure_count < PRINT_CAP)
			$display("ERROR at %0t: %s", $time, what);
		failure_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				checked_count, name, got, exp_val));
	endtask

	// Work out the stall and outcome of one access and advance the store
	function automatic result_t predict_access(access_t acc);
		logic [29:0] word;
		int unsigned line;
		logic [31:0] tag, fetch, word_write, penalty;
		logic        hit, wback;
		result_t     r;
		word = acc.address[31:2];
		line = (32'(word) >> cur_block_log2) & (STORE_DEPTH - 1);
		tag = 32'(word) >> (cur_block_log2 + LINE_BITS);
		wback = (cur_policy >= POL_WB);
		fetch = 32'(cur_setup) + 32'(cur_burst);
		word_write = 32'(cur_setup) + (32'(cur_burst) >> cur_block_log2);
		hit = line_valid[line] && (line_tag[line] == tag);
		penalty = '0;
		r = '0;
		if (acc.opcode == OP_READ) begin
			read_count++;
			if (hit) begin
				hit_count++;
				r.outcome = OUT_HIT;
			end else begin
				miss_count++;
				r.outcome = OUT_MISS;
				penalty = fetch;
				if (wback) begin
					// a dirty victim is written back first
					if (line_dirty[line])
						penalty += fetch;
					line_dirty[line] = 1'b0;
				end
				line_valid[line] = 1'b1;
				line_tag[line] = tag;
			end
		end else begin
			write_count++;
			if (cur_policy == POL_WT_NOALLOC) begin
				r.outcome = OUT_NONE;
				penalty = word_write;
			end else if (hit) begin
				hit_count++;
				r.outcome = OUT_HIT;
				if (wback)
					line_dirty[line] = 1'b1;
				else
					penalty = word_write;
			end else begin
				// fill without charging a dirty eviction
				miss_count++;
				r.outcome = OUT_MISS;
				penalty = word_write + fetch;
				if (wback)
					line_dirty[line] = 1'b0;
				line_valid[line] = 1'b1;
				line_tag[line] = tag;
			end
		end
		r.penalty_cycles = penalty[PENALTY_W-1:0];
		r.hit_total = hit_count;
		r.miss_total = miss_count;
		r.read_total = read_count;
		r.write_total = write_count;
		return r;
	endfunction

	// Driver: present queued accesses in bursts separated by gaps outside quiet stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid <= 1'b0;
			acc_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (acc_valid && acc_ready) begin
				expected_results.push_back(predict_access(acc_data));
				accepted_count++;
			end
			if (!acc_valid || acc_ready) begin
				if (gap_left != 0) begin
					acc_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (access_queue.size() != 0) begin
					acc_valid <= 1'b1;
					acc_data <= access_queue.pop_front();
					if (!quiet_stretch) begin
						if (burst_left <= 1) begin
							burst_left <= $urandom_range(1, 24);
							gap_left <= $urandom_range(1, 6);
						end else begin
							burst_left <= burst_left - 1;
						end
					end
				end else begin
					acc_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall runs, none during quiet stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			res_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			res_ready <= 1'b1;
			if (!quiet_stretch && $urandom_range(0, 7) == 0)
				stall_left <= $urandom_range(1, 9);
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with no access outstanding");
			end else begin
				want = expected_results.pop_front();
				check_field("penalty_cycles", 32'(res_data.penalty_cycles),
					32'(want.penalty_cycles));
				check_field("outcome", 32'(res_data.outcome), 32'(want.outcome));
				check_field("hit_total", res_data.hit_total, want.hit_total);
				check_field("miss_total", res_data.miss_total, want.miss_total);
				check_field("read_total", res_data.read_total, want.read_total);
				check_field("write_total", res_data.write_total, want.write_total);
				outcome_seen[want.outcome]++;
				checked_count++;
			end
		end
	end

	task automatic write_register(input logic [1:0] index, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_WRITE_POLICY: cur_policy = value[1:0];
			CFG_BLOCK_LOG2:   cur_block_log2 = value[3:0];
			CFG_SETUP:        cur_setup = value;
			CFG_BURST:        cur_burst = value;
			default:          ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Program all four registers; unused upper bits carry noise
	task automatic apply_settings(input logic [1:0] policy, input logic [3:0] block_log2,
			input logic [15:0] setup, input logic [15:0] burst);
		write_register(CFG_WRITE_POLICY, {14'($urandom), policy});
		write_register(CFG_BLOCK_LOG2, {12'($urandom), block_log2});
		write_register(CFG_SETUP, setup);
		write_register(CFG_BURST, burst);
		settings_count++;
	endtask

	task automatic queue_access(input logic op, input logic [31:0] address);
		access_t acc;
		acc.opcode = op;
		acc.address = address;
		access_queue.push_back(acc);
	endtask

	// Hold until every queued access has been transferred and answered
	task automatic drain;
		while (access_queue.size() != 0 || acc_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Mostly reuse a few lines and tags to force hits and conflicts
	task automatic queue_random_accesses(input int count);
		logic [31:0] lines [4];
		logic [31:0] tags [3];
		logic [29:0] word;
		int unsigned tag_pos;
		tag_pos = cur_block_log2 + LINE_BITS;
		foreach (lines[i])
			lines[i] = $urandom_range(0, STORE_DEPTH - 1);
		foreach (tags[i])
			tags[i] = $urandom;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 8)
				word = 30'((tags[$urandom_range(0, 2)] << tag_pos)
					| (lines[$urandom_range(0, 3)] << cur_block_log2)
					| ($urandom & ((32'd1 << cur_block_log2) - 1)));
			else
				word = 30'($urandom);
			queue_access(1'($urandom), {word, 2'($urandom)});
		end
	endtask

	// One setting with a full pause halfway through
	task automatic run_phase(input logic [1:0] policy, input logic [3:0] block_log2,
			input logic [15:0] setup, input logic [15:0] burst, input int count,
			input bit quiet);
		quiet_stretch = quiet;
		apply_settings(policy, block_log2, setup, burst);
		queue_random_accesses(count / 2);
		drain;
		queue_random_accesses(count - count / 2);
		drain;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Write-back: hit sets dirty, dirty read miss pays twice, write miss does not
		apply_settings(POL_WB, 4'd2, 16'd10, 16'd40);
		queue_access(OP_READ, 32'h0000_0000);
		queue_access(OP_READ, 32'h0000_0000);
		queue_access(OP_WRITE, 32'h0000_0000);
		queue_access(OP_READ, 32'h0000_1000);
		queue_access(OP_WRITE, 32'hffff_ffff);
		queue_access(OP_READ, 32'hffff_ffff);
		queue_access(OP_WRITE, 32'hffff_fffc);
		queue_access(OP_WRITE, 32'h7fff_fffc);
		drain;

		// Write-through without allocate, one word per block, maximum latencies
		apply_settings(POL_WT_NOALLOC, 4'd0, 16'hffff, 16'hffff);
		queue_access(OP_WRITE, 32'h0000_0004);
		queue_access(OP_READ, 32'h0000_0004);
		queue_access(OP_READ, 32'h0000_0004);
		queue_access(OP_WRITE, 32'h0000_0004);
		queue_access(OP_READ, 32'h0000_0008);
		drain;

		// Write-through with allocate, largest block
		apply_settings(POL_WT_ALLOC, 4'd8, 16'd0, 16'hffff);
		queue_access(OP_WRITE, 32'h0000_0000);
		queue_access(OP_WRITE, 32'h0000_03fc);
		queue_access(OP_READ, 32'h0000_0000);
		queue_access(OP_READ, 32'h8000_0000);
		drain;

		// Spare policy code with an out-of-range block size
		apply_settings(POL_WB_ALIAS, 4'd15, 16'hffff, 16'd0);
		queue_access(OP_WRITE, 32'hffff_fffc);
		queue_access(OP_WRITE, 32'hffff_fffc);
		queue_access(OP_READ, 32'h7fff_fffc);
		drain;

		// Random traffic across a range of settings
		run_phase(POL_WB, 4'd2, 16'd3, 16'd12, 260, 1'b0);
		run_phase(POL_WT_NOALLOC, 4'd0, 16'd1, 16'd1, 200, 1'b1);
		run_phase(POL_WT_ALLOC, 4'd3, 16'd100, 16'd800, 240, 1'b0);
		run_phase(POL_WB, 4'd8, 16'hffff, 16'hffff, 240, 1'b0);
		run_phase(POL_WB_ALIAS, 4'($urandom_range(9, 15)), 16'($urandom), 16'($urandom),
			200, 1'b0);
		run_phase(POL_WB, 4'd0, 16'd0, 16'd0, 200, 1'b1);
		run_phase(POL_WT_ALLOC, 4'd8, 16'hffff, 16'd0, 200, 1'b0);
		repeat (3)
			run_phase(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom), 100,
				1'($urandom));

		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("Covered %0d accesses under %0d register settings, %0d results checked.",
			accepted_count, settings_count, checked_count);
		$display("Outcomes seen: %0d hits, %0d misses, %0d uncached writes.",
			outcome_seen[OUT_HIT], outcome_seen[OUT_MISS], outcome_seen[OUT_NONE]);
		if (failure_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Timeout: %0d results still outstanding", expected_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_tag_store.sv
hw/rtl/dmc_resolve.sv
hw/rtl/direct_mapped_cache_timing_model.sv
verif/direct_mapped_cache_timing_model_tb.sv
